@@ src/trpd_pkg.sv @@
package trpd_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIXEL_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RLE_MODE     = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_PIXELS = 2'd2;

  localparam int CFG_DATA_WIDTH   = 25;
  localparam int PIXEL_BYTES_W    = 3;
  localparam int IMAGE_PIXELS_W   = 25;

  localparam logic [PIXEL_BYTES_W-1:0]  PIXEL_BYTES_RESET  = 3'd3;
  localparam logic [PIXEL_BYTES_W-1:0]  PIXEL_BYTES_BGRA   = 3'd4;
  localparam logic                      RLE_MODE_RESET     = 1'b1;
  localparam logic [IMAGE_PIXELS_W-1:0] IMAGE_PIXELS_RESET = '0;

  localparam int COUNT_WIDTH_DEFAULT = 25;

  // stream constants
  localparam int  RUN_BIT_POS = 7;
  localparam logic [7:0] OPAQUE_ALPHA = 8'd255;
  localparam int PACKET_COUNT_W = 8;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_image;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_first;
    logic [31:0] pixel_second;
    logic        second_valid;
    logic        last_of_packet;
    logic        image_done;
    logic        overrun;
  } out_item_t;

  // one decoded pixel with its repeat count
  typedef struct packed {
    logic                      clear;
    logic [PACKET_COUNT_W-1:0] count;
    logic [31:0]               pix;
  } job_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
  } queue_status_t;

endpackage

@@ src/trpd_front.sv @@
module trpd_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  trpd_pkg::in_item_t                   in_data,
  input  logic [trpd_pkg::PIXEL_BYTES_W-1:0]   pixel_bytes,
  input  logic                                 rle_mode,
  input  trpd_pkg::queue_status_t              q_status,
  output logic                                 push,
  output trpd_pkg::job_t                       push_job
);

  logic                                expect_header_r, expect_header_nxt;
  logic                                is_run_r, is_run_nxt;
  logic [trpd_pkg::PACKET_COUNT_W-1:0] left_r, left_nxt;
  logic [1:0]                          bip_r, bip_nxt;
  logic [31:0]                         asm_r, asm_nxt;
  logic                                pend_clear_r, pend_clear_nxt;

  logic                                accept;
  logic                                eh, run;
  logic [trpd_pkg::PACKET_COUNT_W-1:0] left;
  logic [1:0]                          bip, bip_inc;
  logic [31:0]                         asm_cur, asm_ins;
  logic                                four, complete, clear_flag;
  logic [7:0]                          b;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign four     = (pixel_bytes == trpd_pkg::PIXEL_BYTES_BGRA);

  // decoder state as seen by this byte, after an optional clear
  assign eh         = in_data.new_image ? 1'b1 : expect_header_r;
  assign run        = in_data.new_image ? 1'b0 : is_run_r;
  assign left       = in_data.new_image ? '0 : left_r;
  assign bip        = in_data.new_image ? 2'd0 : bip_r;
  assign asm_cur    = in_data.new_image ? 32'd0 : asm_r;
  assign clear_flag = pend_clear_r || in_data.new_image;
  assign bip_inc    = bip + 2'd1;

  // place the byte: stream order b, g, r, a
  always_comb begin
    asm_ins = asm_cur;
    case (bip)
      2'd0:    asm_ins[23:16] = b;
      2'd1:    asm_ins[15:8]  = b;
      2'd2:    asm_ins[7:0]   = b;
      default: asm_ins[31:24] = b;
    endcase
  end

  assign complete = (bip_inc == 2'd0) || (!four && (bip_inc == 2'd3));

  // packet and pixel tracking
  always_comb begin
    expect_header_nxt = expect_header_r;
    is_run_nxt        = is_run_r;
    left_nxt          = left_r;
    bip_nxt           = bip_r;
    asm_nxt           = asm_r;
    pend_clear_nxt    = pend_clear_r;
    push              = 1'b0;
    push_job.clear    = clear_flag;
    push_job.count    = trpd_pkg::PACKET_COUNT_W'(1);
    push_job.pix      = four ? asm_ins : {trpd_pkg::OPAQUE_ALPHA, asm_ins[23:0]};
    if (accept) begin
      expect_header_nxt = eh;
      is_run_nxt        = run;
      left_nxt          = left;
      pend_clear_nxt    = clear_flag;
      if (rle_mode && eh) begin
        is_run_nxt        = b[trpd_pkg::RUN_BIT_POS];
        left_nxt          = {1'b0, b[6:0]} + trpd_pkg::PACKET_COUNT_W'(1);
        expect_header_nxt = 1'b0;
        bip_nxt           = 2'd0;
        asm_nxt           = 32'd0;
      end else if (!complete) begin
        bip_nxt = bip_inc;
        asm_nxt = asm_ins;
      end else begin
        bip_nxt        = 2'd0;
        asm_nxt        = 32'd0;
        push           = 1'b1;
        pend_clear_nxt = 1'b0;
        if (rle_mode) begin
          if (run) begin
            push_job.count    = left;
            left_nxt          = '0;
            expect_header_nxt = 1'b1;
          end else begin
            if (left > 1) begin
              left_nxt = left - trpd_pkg::PACKET_COUNT_W'(1);
            end else begin
              left_nxt          = '0;
              expect_header_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r <= 1'b1;
      is_run_r        <= 1'b0;
      left_r          <= '0;
      bip_r           <= 2'd0;
      asm_r           <= 32'd0;
      pend_clear_r    <= 1'b0;
    end else begin
      expect_header_r <= expect_header_nxt;
      is_run_r        <= is_run_nxt;
      left_r          <= left_nxt;
      bip_r           <= bip_nxt;
      asm_r           <= asm_nxt;
      pend_clear_r    <= pend_clear_nxt;
    end
  end

endmodule

@@ src/trpd_queue.sv @@
module trpd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  trpd_pkg::job_t          push_job,
  output trpd_pkg::queue_status_t status,
  output logic                    q_valid,
  output trpd_pkg::job_t          q_job,
  input  logic                    pop
);

  localparam int PW = (trpd_pkg::QUEUE_DEPTH > 1) ? $clog2(trpd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(trpd_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(trpd_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0]   LAST_C  = PW'(trpd_pkg::QUEUE_DEPTH - 1);

  trpd_pkg::job_t mem_r [trpd_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign status.full = (cnt_r == DEPTH_C);
  assign q_valid     = (cnt_r != '0);
  assign q_job       = mem_r[rd_ptr_r];
  assign do_push     = push && !status.full;
  assign do_pop      = pop && q_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ src/trpd_back.sv @@
module trpd_back #(
  parameter int COUNT_WIDTH = trpd_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [trpd_pkg::IMAGE_PIXELS_W-1:0]  image_pixels,
  input  logic                                 q_valid,
  input  trpd_pkg::job_t                       q_job,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output trpd_pkg::out_item_t                  out_data
);

  localparam int WIDE = (COUNT_WIDTH > trpd_pkg::IMAGE_PIXELS_W) ?
                        COUNT_WIDTH : trpd_pkg::IMAGE_PIXELS_W;
  localparam int MW = WIDE + 2;
  localparam logic [MW-1:0] COUNT_MAX = MW'({COUNT_WIDTH{1'b1}});

  logic                                loaded_r, loaded_nxt;
  logic [31:0]                         pix_r, pix_nxt;
  logic [trpd_pkg::PACKET_COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0]              emitted_r, emitted_nxt;
  logic                                ovr_r, ovr_nxt;
  logic                                out_valid_r, out_valid_nxt;
  trpd_pkg::out_item_t                 out_data_r, out_data_nxt;

  logic [MW-1:0] img, lim, em, em_t, rem_w;
  logic          can1, can2, beat, last, done, drop;
  logic [1:0]    t;
  logic [trpd_pkg::PACKET_COUNT_W-1:0] rem_left;

  // how many pixels of the current job fit before the limit
  assign img   = MW'(image_pixels);
  assign lim   = (img < COUNT_MAX) ? img : COUNT_MAX;
  assign em    = MW'(emitted_r);
  assign rem_w = MW'(rem_r);
  assign can1  = (em < lim) && (rem_r != '0);
  assign can2  = can1 && (rem_r > trpd_pkg::PACKET_COUNT_W'(1)) && ((em + MW'(1)) < lim);
  assign t     = can2 ? 2'd2 : (can1 ? 2'd1 : 2'd0);
  assign em_t  = em + MW'(t);
  assign rem_left = rem_r - trpd_pkg::PACKET_COUNT_W'(t);
  assign last  = (t == 2'd0) || (rem_left == '0) || (em_t >= lim);
  assign done  = (t == 2'd0) || (em_t >= img);
  assign drop  = (em + rem_w) > lim;

  assign beat = loaded_r && (!out_valid_r || out_ready);
  assign pop  = q_valid && (!loaded_r || (beat && last));

  // result formation and job sequencing
  always_comb begin
    loaded_nxt    = loaded_r;
    pix_nxt       = pix_r;
    rem_nxt       = rem_r;
    emitted_nxt   = emitted_r;
    ovr_nxt       = ovr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (beat) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.pixel_first    = (t != 2'd0) ? pix_r : 32'd0;
      out_data_nxt.pixel_second   = (t == 2'd2) ? pix_r : 32'd0;
      out_data_nxt.second_valid   = (t == 2'd2);
      out_data_nxt.last_of_packet = 1'b1;
      out_data_nxt.last_of_packet = last;
      out_data_nxt.image_done     = done;
      out_data_nxt.overrun        = ovr_r || drop;
      emitted_nxt                 = em_t[COUNT_WIDTH-1:0];
      rem_nxt                     = rem_left;
      ovr_nxt                     = ovr_r || drop;
      if (last) begin
        loaded_nxt = 1'b0;
      end
    end
    if (pop) begin
      loaded_nxt = 1'b1;
      pix_nxt    = q_job.pix;
      rem_nxt    = q_job.count;
      if (q_job.clear) begin
        emitted_nxt = '0;
        ovr_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= 1'b0;
      emitted_r   <= '0;
      ovr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      loaded_r    <= loaded_nxt;
      emitted_r   <= emitted_nxt;
      ovr_r       <= ovr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/tga_rle_pixel_decoder.sv @@
// a completed pixel passes the job queue, the back end job registers and the output register
// throughput: one byte per cycle; the back end emits one result (up to two pixels) per cycle
//   while the receiver takes them; runs pack two pixels per result, literal pixels one each
// input stalls only when the two-entry job queue between front and back is full
// reset: synchronous active-low rst_n empties the queue and output register, restores
//   pixel_bytes 3, rle_mode 1, image_pixels 0 and expects a packet header
module tga_rle_pixel_decoder #(
  parameter int COUNT_WIDTH = trpd_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  trpd_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output trpd_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [trpd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [trpd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  logic [trpd_pkg::PIXEL_BYTES_W-1:0]  pixel_bytes_r, pixel_bytes_nxt;
  logic                                rle_mode_r, rle_mode_nxt;
  logic [trpd_pkg::IMAGE_PIXELS_W-1:0] image_pixels_r, image_pixels_nxt;

  trpd_pkg::queue_status_t q_status;
  trpd_pkg::job_t          push_job, q_job;
  logic                    push, q_valid, pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    pixel_bytes_nxt  = pixel_bytes_r;
    rle_mode_nxt     = rle_mode_r;
    image_pixels_nxt = image_pixels_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        trpd_pkg::CFG_PIXEL_BYTES:  pixel_bytes_nxt  = cfg_data[trpd_pkg::PIXEL_BYTES_W-1:0];
        trpd_pkg::CFG_RLE_MODE:     rle_mode_nxt     = cfg_data[0];
        trpd_pkg::CFG_IMAGE_PIXELS: image_pixels_nxt = cfg_data[trpd_pkg::IMAGE_PIXELS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bytes_r  <= trpd_pkg::PIXEL_BYTES_RESET;
      rle_mode_r     <= trpd_pkg::RLE_MODE_RESET;
      image_pixels_r <= trpd_pkg::IMAGE_PIXELS_RESET;
    end else begin
      pixel_bytes_r  <= pixel_bytes_nxt;
      rle_mode_r     <= rle_mode_nxt;
      image_pixels_r <= image_pixels_nxt;
    end
  end

  // byte parsing and pixel assembly
  trpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .pixel_bytes (pixel_bytes_r),
    .rle_mode    (rle_mode_r),
    .q_status    (q_status),
    .push        (push),
    .push_job    (push_job)
  );

  // decoupling queue
  trpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .status   (q_status),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (pop)
  );

  // pixel counting and result emission
  trpd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_pixels (image_pixels_r),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

@@ src/trpd_checker.sv @@
module trpd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input trpd_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // both pixels of a result come from the same run
  a_pair_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.second_valid |-> out_data.pixel_second == out_data.pixel_first)
    else $error("pixel pair differs");

  // an empty second slot reads zero
  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.second_valid |-> out_data.pixel_second == 32'd0)
    else $error("unflagged second pixel not zero");

  // reset empties the output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind tga_rle_pixel_decoder trpd_checker u_trpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/tga_rle_pixel_decoder_checker.sv @@
module tga_rle_pixel_decoder_checker
  import trpd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  in_item_t                   in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  out_item_t                  out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                         mismatches,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [PIXEL_BYTES_W-1:0]       bpp_sel;
  logic                           rle_on;
  logic [IMAGE_PIXELS_W-1:0]      pixel_total;

  // decoder copy
  logic                           await_header;
  logic                           run_packet;
  logic [PACKET_COUNT_W-1:0]      packet_left;
  logic [1:0]                     byte_slot;
  logic [31:0]                    pix_build;
  logic [COUNT_WIDTH_DEFAULT-1:0] pix_count;
  logic                           dropped_any;

  out_item_t rgba_due[$];
  out_item_t want;
  int        err_count = 0;

  task automatic start_image();
    await_header = 1'b1;
    run_packet   = 1'b0;
    packet_left  = '0;
    byte_slot    = '0;
    pix_build    = '0;
    pix_count    = '0;
    dropped_any  = 1'b0;
  endtask

  // queue the words for copies of one pixel, two pixels per word, clipped to the image size
  task automatic emit_repeats(input logic [31:0] pix, input int unsigned copies);
    int unsigned start_cnt, room, kept, words, used, k;
    out_item_t   w;
    start_cnt = 32'(pix_count);
    room      = (pixel_total > pix_count) ? 32'(pixel_total - pix_count) : 0;
    kept      = (room < copies) ? room : copies;
    if (kept < copies) dropped_any = 1'b1;
    pix_count = COUNT_WIDTH_DEFAULT'(start_cnt + kept);
    if (kept == 0) begin
      w = '{pixel_first: '0, pixel_second: '0, second_valid: 1'b0, last_of_packet: 1'b1,
            image_done: 1'b1, overrun: dropped_any};
      rgba_due.push_back(w);
      return;
    end
    words = (kept + 1) / 2;
    for (k = 0; k < words; k++) begin
      used             = (2 * k + 2 > kept) ? kept : 2 * k + 2;
      w.pixel_first    = pix;
      w.second_valid   = (2 * k + 1 < kept);
      w.pixel_second   = w.second_valid ? pix : '0;
      w.last_of_packet = (k == words - 1);
      w.image_done     = (start_cnt + used >= 32'(pixel_total));
      w.overrun        = dropped_any;
      rgba_due.push_back(w);
    end
  endtask

  // one stream byte: header, partial pixel or completed pixel
  task automatic decode_byte(input in_item_t it);
    logic [31:0] pix;
    int unsigned width_bytes, copies;
    width_bytes = (bpp_sel == PIXEL_BYTES_BGRA) ? 4 : 3;
    if (it.new_image) start_image();
    if (rle_on && await_header) begin
      run_packet   = it.data_byte[RUN_BIT_POS];
      packet_left  = {1'b0, it.data_byte[6:0]} + 1'b1;
      await_header = 1'b0;
      byte_slot    = '0;
      pix_build    = '0;
      return;
    end
    // stream order is B, G, R, A
    case (byte_slot)
      2'd0:    pix_build[23:16] = it.data_byte;
      2'd1:    pix_build[15:8]  = it.data_byte;
      2'd2:    pix_build[7:0]   = it.data_byte;
      default: pix_build[31:24] = it.data_byte;
    endcase
    byte_slot = byte_slot + 1'b1;
    if (byte_slot != 0 && 32'(byte_slot) < width_bytes) return;
    pix = pix_build;
    if (width_bytes == 3) pix[31:24] = OPAQUE_ALPHA;
    byte_slot = '0;
    pix_build = '0;
    if (!rle_on) begin
      emit_repeats(pix, 1);
    end else if (run_packet) begin
      copies       = 32'(packet_left);
      packet_left  = '0;
      await_header = 1'b1;
      emit_repeats(pix, copies);
    end else begin
      if (packet_left != 0) packet_left = packet_left - 1'b1;
      if (packet_left == 0) await_header = 1'b1;
      emit_repeats(pix, 1);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %h actual %h", $time, field, exp_v, got_v);
      err_count++;
    end
  endtask

  // sample all three channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      bpp_sel     = PIXEL_BYTES_RESET;
      rle_on      = RLE_MODE_RESET;
      pixel_total = IMAGE_PIXELS_RESET;
      start_image();
      rgba_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PIXEL_BYTES:  bpp_sel     = cfg_data[PIXEL_BYTES_W-1:0];
          CFG_RLE_MODE:     rle_on      = cfg_data[0];
          CFG_IMAGE_PIXELS: pixel_total = cfg_data[IMAGE_PIXELS_W-1:0];
          default: ;
        endcase
      end
      // compare against the oldest word before queueing new ones
      if (out_valid && out_ready) begin
        if (rgba_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
          err_count++;
        end else begin
          want = rgba_due.pop_front();
          check_field("pixel_first", want.pixel_first, out_data.pixel_first);
          check_field("pixel_second", want.pixel_second, out_data.pixel_second);
          check_field("second_valid", 32'(want.second_valid), 32'(out_data.second_valid));
          check_field("last_of_packet", 32'(want.last_of_packet),
                      32'(out_data.last_of_packet));
          check_field("image_done", 32'(want.image_done), 32'(out_data.image_done));
          check_field("overrun", 32'(want.overrun), 32'(out_data.overrun));
        end
      end
      if (in_valid && in_ready) decode_byte(in_data);
    end
    mismatches <= err_count;
    pending    <= rgba_due.size();
  end

endmodule

@@ tb/tga_rle_pixel_decoder_tb.sv @@
module tga_rle_pixel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trpd_pkg::*;

  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 25;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  // index past the register map, writes to it are dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  in_item_t                   in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  out_item_t                  out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
  int                         mismatches;
  int                         pending;

  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_timer     = 0;
  int       idle_cycles  = 0;
  int       burst_left   = 0;
  bit       gaps_on      = 1'b1;
  int       phase_sent   = 0;
  int       stream_bytes = 3;
  bit       stream_rle   = 1'b1;

  // run of 2, run of 128 white, literal of 2, literal of 1 (new image)
  logic [7:0] directed_bytes [24] = '{
    8'h81, 8'h00, 8'hFF, 8'h12, 8'h34,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h5A, 8'hC3, 8'h3C,
    8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE
  };

  always #6 clk = ~clk;

  tga_rle_pixel_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tga_rle_pixel_decoder_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // receiver backpressure, mode reshuffled whenever its timer runs out
  always @(posedge clk) begin
    if (rx_timer == 0) begin
      rx_mode  <= rx_mode_t'($urandom_range(3, 0));
      rx_timer <= $urandom_range(80, 16);
    end else begin
      rx_timer <= rx_timer - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(3, 0) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(3, 0) == 0);
      default:  out_ready <= rx_timer[2];
    endcase
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one stream byte, with random gaps between bursts when gaps are enabled
  task automatic push_byte(input logic [7:0] b, input logic ni);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = $urandom_range(12, 1);
    end
    in_data  <= '{data_byte: b, new_image: ni};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    phase_sent++;
  endtask

  task automatic push_pixel(input logic ni);
    int k;
    for (k = 0; k < stream_bytes; k++) push_byte(8'($urandom_range(255, 0)), ni && k == 0);
  endtask

  // hold the input until every queued word is out, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // unused upper data bits carry noise
  task automatic apply_config(input logic [PIXEL_BYTES_W-1:0] bpp, input logic rle,
                              input logic [IMAGE_PIXELS_W-1:0] total, input bit poke_unused);
    logic [CFG_DATA_WIDTH-1:0] noise;
    noise = CFG_DATA_WIDTH'($urandom());
    cfg_write(CFG_PIXEL_BYTES, {noise[CFG_DATA_WIDTH-1:PIXEL_BYTES_W], bpp});
    noise = CFG_DATA_WIDTH'($urandom());
    cfg_write(CFG_RLE_MODE, {noise[CFG_DATA_WIDTH-1:1], rle});
    cfg_write(CFG_IMAGE_PIXELS, total);
    if (poke_unused) cfg_write(CFG_UNUSED_INDEX, CFG_DATA_WIDTH'($urandom()));
    cfg_valid    <= 1'b0;
    stream_bytes = (bpp == PIXEL_BYTES_BGRA) ? 4 : 3;
    stream_rle   = rle;
  endtask

  initial begin
    int                        phase, k, roll;
    logic [PIXEL_BYTES_W-1:0]  bpp;
    logic                      rle;
    logic [IMAGE_PIXELS_W-1:0] total;
    logic [7:0]                hdr;
    logic                      ni;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each packet kind in BGRA, no pixel limit
    apply_config(PIXEL_BYTES_BGRA, 1'b1, '1, 1'b1);
    for (k = 0; k < 24; k++) push_byte(directed_bytes[k], k == 0 || k == 19);

    // random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin bpp = 3'd0;              rle = 1'b0; total = 25'd7;        end
        1: begin bpp = 3'd7;              rle = 1'b1; total = '1;           end
        2: begin bpp = PIXEL_BYTES_BGRA;  rle = 1'b0; total = 25'd16777216; end
        3: begin bpp = PIXEL_BYTES_RESET; rle = 1'b1; total = '0;           end
        default: begin
          if ($urandom_range(2, 0) == 0)
            bpp = PIXEL_BYTES_W'($urandom_range(7, 0));
          else
            bpp = $urandom_range(1, 0) ? PIXEL_BYTES_BGRA : PIXEL_BYTES_RESET;
          rle = 1'($urandom_range(1, 0));
          case ($urandom_range(4, 0))
            0:       total = '0;
            1:       total = IMAGE_PIXELS_W'($urandom_range(40, 1));
            2:       total = IMAGE_PIXELS_W'($urandom_range(600, 41));
            3:       total = 25'd16777216;
            default: total = '1;
          endcase
        end
      endcase
      apply_config(bpp, rle, total, $urandom_range(3, 0) == 0);
      gaps_on    = ($urandom_range(3, 0) != 0);
      burst_left = 0;
      phase_sent = 0;

      while (phase_sent < PHASE_ITEMS) begin
        ni   = ($urandom_range(15, 0) == 0);
        roll = $urandom_range(19, 0);
        if (roll == 0) begin
          // stray byte anywhere in the stream
          push_byte(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
        end else if (roll == 1) begin
          settle();
        end else if (!stream_rle) begin
          push_pixel(ni);
        end else begin
          hdr[7] = 1'($urandom_range(1, 0));
          if (hdr[7])
            hdr[6:0] = ($urandom_range(5, 0) == 0) ? 7'($urandom_range(127, 8)) :
                                                      7'($urandom_range(7, 0));
          else
            hdr[6:0] = ($urandom_range(11, 0) == 0) ? 7'($urandom_range(20, 8)) :
                                                       7'($urandom_range(7, 0));
          push_byte(hdr, ni);
          if (roll == 2) begin
            // packet cut short, the stream falls out of step
            repeat ($urandom_range(5, 0)) push_byte(8'($urandom_range(255, 0)), 1'b0);
          end else begin
            repeat (hdr[7] ? 1 : hdr[6:0] + 1) push_pixel(1'b0);
          end
        end
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/trpd_pkg.sv
src/trpd_front.sv
src/trpd_queue.sv
src/trpd_back.sv
src/tga_rle_pixel_decoder.sv
src/trpd_checker.sv
tb/tga_rle_pixel_decoder_checker.sv
tb/tga_rle_pixel_decoder_tb.sv
